// ===== hw/rtl/multichannel_block_averager_core_macros.svh =====
// Assertion macros for the checker module.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef MULTICHANNEL_BLOCK_AVERAGER_CORE_MACROS_SVH
`define MULTICHANNEL_BLOCK_AVERAGER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mba_pkg.sv =====
package mba_pkg;

    // Fixed field widths of the request and result channels.
    localparam int SAMPLE_BITS   = 16;
    localparam int CH_BITS       = 4;
    localparam int BLOCKS_BITS   = 11;
    localparam int LEN_CFG_BITS  = 11;
    localparam int MAXB_BITS     = 10;
    localparam int TRACK_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    // The block counter saturates at its field maximum.
    localparam logic [BLOCKS_BITS-1:0] BLOCKS_MAX = '1;

    // Register reset values.
    localparam logic [LEN_CFG_BITS-1:0] BLOCK_LENGTH_RST    = 11'd1;
    localparam logic [MAXB_BITS-1:0]    MAX_BLOCKS_RST      = 10'd1000;
    localparam logic [TRACK_BITS-1:0]   TRACKED_CHANNEL_RST = 4'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BLOCK_LENGTH    = 2'd0,
        REG_MAX_BLOCKS      = 2'd1,
        REG_TRACKED_CHANNEL = 2'd2
    } cfg_reg_t;

    // Status that every result carries.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic [BLOCKS_BITS-1:0] blocks_done;
        logic                   halted;
    } status_t;

    // Control part of one job handed from the front end to the back end.
    typedef struct packed {
        logic               need_div;
        logic [CH_BITS-1:0] channel;
        status_t            status;
    } job_ctl_t;

endpackage

// ===== hw/rtl/mba_if.sv =====
// Request channel: one sample and its channel index.
interface mba_in_if;
    import mba_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_BITS-1:0]            channel;

    modport source (output valid, sample, channel, input ready);
    modport sink (input valid, sample, channel, output ready);
endinterface

// Result channel: one average slot plus the running status.
interface mba_out_if;
    import mba_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          average_valid;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [CH_BITS-1:0]            average_channel;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic [BLOCKS_BITS-1:0]        blocks_done;
    logic                          halted;

    modport source (output valid, average_valid, average, average_channel, minimum,
                    maximum, blocks_done, halted, input ready);
    modport sink (input valid, average_valid, average, average_channel, minimum,
                  maximum, blocks_done, halted, output ready);
endinterface

// ===== hw/rtl/mba_queue.sv =====
module mba_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    data_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = data_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule

// ===== hw/rtl/mba_front.sv =====
module mba_front #(
    parameter int CHANNELS         = 13,
    parameter int MAX_BLOCK_LENGTH = 1024,
    parameter int SUM_BITS         = 32,
    parameter int LEN_BITS         = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mba_in_if.sink                             in_ch,
    input  logic                               cfg_we,
    input  logic [mba_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mba_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output mba_pkg::job_ctl_t                  q_ctl,
    output logic [SUM_BITS-1:0]                q_sum,
    output logic [LEN_BITS-1:0]                q_len
);
    import mba_pkg::*;

    localparam int RC_BITS  = $clog2(MAX_BLOCK_LENGTH);
    localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LENX     = LEN_BITS + 1;

    logic [LEN_CFG_BITS-1:0]       block_length_reg;
    logic [MAXB_BITS-1:0]          max_blocks_reg;
    logic [TRACK_BITS-1:0]         tracked_reg;

    logic [SUM_BITS-1:0]           sums_reg [CHANNELS];
    logic [RC_BITS-1:0]            rc_reg;
    logic [RC_BITS-1:0]            rc_next;
    logic [BLOCKS_BITS-1:0]        bc_reg;
    logic [BLOCKS_BITS-1:0]        bc_next;
    logic signed [SAMPLE_BITS-1:0] low_reg;
    logic signed [SAMPLE_BITS-1:0] low_next;
    logic signed [SAMPLE_BITS-1:0] high_reg;
    logic signed [SAMPLE_BITS-1:0] high_next;
    logic                          seen_reg;
    logic                          seen_next;
    logic                          stop_reg;
    logic                          stop_next;

    logic [LEN_BITS-1:0]           len_eff;
    logic [31:0]                   ch_ext;
    logic [IDX_BITS-1:0]           idx;
    logic                          ch_ok;
    logic                          is_last_ch;
    logic                          is_tracked;
    logic                          active;
    logic [LENX-1:0]               rc_inc;
    logic                          last_rec;
    logic [SUM_BITS-1:0]           sum_new;

    // Zero length counts as one; lengths above the maximum saturate.
    always_comb
    begin
        if (block_length_reg == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (32'(block_length_reg) > 32'(MAX_BLOCK_LENGTH))
        begin
            len_eff = LEN_BITS'(MAX_BLOCK_LENGTH);
        end
        else
        begin
            len_eff = LEN_BITS'(block_length_reg);
        end
    end

    // Classify the request.
    assign ch_ext     = 32'(in_ch.channel);
    assign idx        = ch_ext[IDX_BITS-1:0];
    assign ch_ok      = ch_ext < 32'(CHANNELS);
    assign is_last_ch = ch_ext == 32'(CHANNELS - 1);
    assign is_tracked = ch_ok && (in_ch.channel == tracked_reg);
    assign active     = !stop_reg && ch_ok;
    assign rc_inc     = LENX'(rc_reg) + 1'b1;
    assign last_rec   = rc_inc >= LENX'(len_eff);

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    // Next values of the running state.
    always_comb
    begin
        sum_new   = sums_reg[idx]
                  + {{(SUM_BITS - SAMPLE_BITS){in_ch.sample[SAMPLE_BITS-1]}}, in_ch.sample};
        low_next  = low_reg;
        high_next = high_reg;
        seen_next = seen_reg;
        rc_next   = rc_reg;
        bc_next   = bc_reg;
        stop_next = stop_reg;
        // The first tracked sample sets both extremes.
        if (active && is_tracked)
        begin
            if (!seen_reg || (in_ch.sample < low_reg))
            begin
                low_next = in_ch.sample;
            end
            if (!seen_reg || (in_ch.sample > high_reg))
            begin
                high_next = in_ch.sample;
            end
            seen_next = 1'b1;
        end
        // The last channel closes a record and possibly a block.
        if (active && is_last_ch)
        begin
            if (last_rec)
            begin
                rc_next = '0;
                if (bc_reg != BLOCKS_MAX)
                begin
                    bc_next = bc_reg + 1'b1;
                end
            end
            else
            begin
                rc_next = rc_inc[RC_BITS-1:0];
            end
            stop_next = bc_next > BLOCKS_BITS'(max_blocks_reg);
        end
    end

    // Job handed to the back end.
    always_comb
    begin
        q_ctl.need_div           = active && last_rec;
        q_ctl.channel            = in_ch.channel;
        q_ctl.status.minimum     = low_next;
        q_ctl.status.maximum     = high_next;
        q_ctl.status.blocks_done = bc_next;
        q_ctl.status.halted      = stop_next;
    end
    assign q_sum = sum_new;
    assign q_len = len_eff;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RST;
            max_blocks_reg   <= MAX_BLOCKS_RST;
            tracked_reg      <= TRACKED_CHANNEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_LENGTH:    block_length_reg <= cfg_data;
                REG_MAX_BLOCKS:      max_blocks_reg   <= cfg_data[MAXB_BITS-1:0];
                REG_TRACKED_CHANNEL: tracked_reg      <= cfg_data[TRACK_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Running state, updated on every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
            rc_reg   <= '0;
            bc_reg   <= '0;
            low_reg  <= '0;
            high_reg <= '0;
            seen_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (q_push)
        begin
            if (active)
            begin
                sums_reg[idx] <= last_rec ? '0 : sum_new;
            end
            rc_reg   <= rc_next;
            bc_reg   <= bc_next;
            low_reg  <= low_next;
            high_reg <= high_next;
            seen_reg <= seen_next;
            stop_reg <= stop_next;
        end
    end
endmodule

// ===== hw/rtl/mba_back.sv =====
module mba_back #(
    parameter int SUM_BITS = 32,
    parameter int LEN_BITS = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  mba_pkg::job_ctl_t   q_ctl,
    input  logic [SUM_BITS-1:0] q_sum,
    input  logic [LEN_BITS-1:0] q_len,
    mba_out_if.source           out_ch
);
    import mba_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_BITS);
    localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } back_state_t;

    back_state_t            state_reg;
    job_ctl_t               ctl_reg;
    logic                   neg_reg;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [LEN_BITS-1:0]    rem_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic [CNT_BITS-1:0]    cnt_reg;

    logic                   out_valid_reg;
    logic                   avg_valid_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [CH_BITS-1:0]     avg_ch_reg;
    status_t                status_reg;

    logic [LEN_BITS:0]      rem_shift;
    logic [LEN_BITS+1:0]    diff;
    logic                   take;
    logic [SUM_BITS-1:0]    quo_neg;
    logic [SAMPLE_BITS-1:0] avg_sat;
    logic                   out_free;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || out_ch.ready;

    // One restoring division step per cycle on the magnitude.
    assign rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, len_reg};
    assign take      = !diff[LEN_BITS+1];

    // Apply the sign and clamp to the sample range; zero when no average is due.
    assign quo_neg = -quo_reg;
    always_comb
    begin
        if (!ctl_reg.need_div)
        begin
            avg_sat = '0;
        end
        else if (neg_reg)
        begin
            avg_sat = (quo_reg > NEG_LIMIT) ? NEG_LIMIT[SAMPLE_BITS-1:0]
                                            : quo_neg[SAMPLE_BITS-1:0];
        end
        else
        begin
            avg_sat = (quo_reg > POS_LIMIT) ? POS_LIMIT[SAMPLE_BITS-1:0]
                                            : quo_reg[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer: take a job, divide if needed, hand over to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= q_ctl.need_div ? S_DIV : S_DONE;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ctl_reg <= q_ctl;
            neg_reg <= q_sum[SUM_BITS-1];
            quo_reg <= q_sum[SUM_BITS-1] ? -q_sum : q_sum;
            rem_reg <= '0;
            len_reg <= q_len;
            cnt_reg <= CNT_BITS'(SUM_BITS - 1);
        end
        else if (state_reg == S_DIV)
        begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], take};
            rem_reg <= take ? diff[LEN_BITS-1:0] : rem_shift[LEN_BITS-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Output register: holds a finished result while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            avg_valid_reg <= ctl_reg.need_div;
            avg_reg       <= avg_sat;
            avg_ch_reg    <= ctl_reg.need_div ? ctl_reg.channel : '0;
            status_reg    <= ctl_reg.status;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.average_valid   = avg_valid_reg;
    assign out_ch.average         = avg_reg;
    assign out_ch.average_channel = avg_ch_reg;
    assign out_ch.minimum         = status_reg.minimum;
    assign out_ch.maximum         = status_reg.maximum;
    assign out_ch.blocks_done     = status_reg.blocks_done;
    assign out_ch.halted          = status_reg.halted;
endmodule

// ===== hw/rtl/multichannel_block_averager_core.sv =====
// Multichannel block averager.
// Requests arrive on in_ch: one signed sample and its channel index; the
// samples of channels 0 up to CHANNELS-1 form a record. Every request gives
// exactly one result on out_ch, carrying the block average when the request
// belongs to the last record of a block, plus the tracked channel's minimum
// and maximum, the finished block count and the halt flag.
// The front end updates all running state in the cycle a request is taken and
// posts a job into a two-entry queue. The back end divides the channel sum by
// the block length with a restoring divider, one quotient bit per cycle.
// A request that yields an average passes the back end states idle, divide
// and done before the output register; any other request skips the divide
// state. The back end finishes one job before it takes the next.
// Reset clears all sums, counters, extremes and the halt flag at once and
// loads the register defaults. A stalled receiver holds the result in the
// output register; the back end then stops, the queue fills, and in_ch.ready
// drops until space frees up. Registers are to be written through cfg_we,
// cfg_index and cfg_data while no request is in flight; the block does not check this.
module multichannel_block_averager_core #(
    parameter int CHANNELS         = 13,
    parameter int MAX_BLOCK_LENGTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mba_in_if.sink                             in_ch,
    mba_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [mba_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mba_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import mba_pkg::*;

    // Sum width leaves headroom for a channel repeated within one record.
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_BLOCK_LENGTH) + 6;
    localparam int LEN_BITS = $clog2(MAX_BLOCK_LENGTH + 1);
    localparam int CTL_BITS = $bits(job_ctl_t);
    localparam int QW       = CTL_BITS + SUM_BITS + LEN_BITS;

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    job_ctl_t            f_ctl;
    logic [SUM_BITS-1:0] f_sum;
    logic [LEN_BITS-1:0] f_len;
    logic [QW-1:0]       q_wdata;
    logic [QW-1:0]       q_rdata;
    job_ctl_t            b_ctl;
    logic [SUM_BITS-1:0] b_sum;
    logic [LEN_BITS-1:0] b_len;

    // Front end: takes requests and keeps the running state.
    mba_front #(
        .CHANNELS         (CHANNELS),
        .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
        .SUM_BITS         (SUM_BITS),
        .LEN_BITS         (LEN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctl     (f_ctl),
        .q_sum     (f_sum),
        .q_len     (f_len)
    );

    // Job queue between the two ends.
    assign q_wdata = {f_ctl, f_sum, f_len};

    mba_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    assign b_ctl = q_rdata[QW-1 -: CTL_BITS];
    assign b_sum = q_rdata[LEN_BITS +: SUM_BITS];
    assign b_len = q_rdata[LEN_BITS-1:0];

    // Back end: division, clamping and the output register.
    mba_back #(
        .SUM_BITS (SUM_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_ctl   (b_ctl),
        .q_sum   (b_sum),
        .q_len   (b_len),
        .out_ch  (out_ch)
    );
endmodule

// ===== hw/rtl/mba_checker.sv =====
`include "multichannel_block_averager_core_macros.svh"

module mba_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             out_halted,
    input logic [mba_pkg::BLOCKS_BITS-1:0]  out_blocks_done,
    input logic [mba_pkg::SAMPLE_BITS-1:0]  out_minimum,
    input logic [mba_pkg::SAMPLE_BITS-1:0]  out_maximum
);
    import mba_pkg::*;

    // A stalled result stays offered.
    `MBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A halted result is followed directly by either no result or a halted one.
    `MBA_ASSERT_NEXT(a_halt_sticky, out_valid && out_halted, !out_valid || out_halted, "halt flag cleared")

    // The finished block count does not go down between back-to-back results.
    `MBA_ASSERT_NEXT(a_blocks_mono, out_valid, !out_valid || (out_blocks_done >= $past(out_blocks_done)), "block count decreased")

    // The tracked minimum never exceeds the tracked maximum.
    `MBA_ASSERT_NOW(a_min_le_max, out_valid, $signed(out_minimum) <= $signed(out_maximum), "minimum above maximum")
endmodule

bind multichannel_block_averager_core mba_checker u_mba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_halted      (out_ch.halted),
    .out_blocks_done (out_ch.blocks_done),
    .out_minimum     (out_ch.minimum),
    .out_maximum     (out_ch.maximum)
);
